### hdl/shared_pool_multi_stack_assert.svh
// ----------------------------------------------------------------------------
// shared pool multi stack assertion macros
// implication checks on the rising clock, muted while reset is high
// ----------------------------------------------------------------------------
`ifndef SHARED_POOL_MULTI_STACK_ASSERT_SVH
`define SHARED_POOL_MULTI_STACK_ASSERT_SVH

// same-cycle implication
`define SPS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("shared pool multi stack: same-cycle check failed");

// next-cycle implication
`define SPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("shared pool multi stack: next-cycle check failed");

`endif

### hdl/sps_pkg.sv
// ----------------------------------------------------------------------------
// sps_pkg
// sizes, codes and types shared by the shared pool multi stack
// ----------------------------------------------------------------------------
package sps_pkg;

  localparam int NUM_STACKS = 8;
  localparam int NUM_SLOTS  = 64;

  localparam int DATA_W = 32;
  localparam int SID_W  = 3;
  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int LINK_W = $clog2(NUM_SLOTS + 1);
  localparam int STK_W  = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;

  // null link sits one past the last slot
  localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(NUM_SLOTS);

  // operation codes
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

endpackage

### hdl/shared_pool_multi_stack.sv
// ----------------------------------------------------------------------------
// shared_pool_multi_stack
// several lifo stacks sharing one pool of slots chained through a free list
// ----------------------------------------------------------------------------
//  channel  | handshake                   | payload
//  ---------+-----------------------------+------------------------------
//  in       | in_valid / in_stall         | cmd, stack_id, value
//  out      | out_valid / out_stall       | status, popped_value
//
//  on the accept edge a beat reads the link and data memories into
//  registers; the commit edge in ST_EXEC writes back and loads the output
//  register. the registered link read means a new beat is taken only
//  after the last has written back. reset runs no clearing pass:
//  per-slot valid bits make unwritten links read as the initial chain.
//  a stalled result holds the block in its write-back cycle; the input
//  stalls during that cycle as well.
// ----------------------------------------------------------------------------
module shared_pool_multi_stack (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             cmd,
  input  logic [sps_pkg::SID_W-1:0]        stack_id,
  input  logic signed [sps_pkg::DATA_W-1:0] value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       status,
  output logic signed [sps_pkg::DATA_W-1:0] popped_value
);

  // state and memories
  sps_pkg::state_t                state;
  logic [sps_pkg::LINK_W-1:0]     stack_top [sps_pkg::NUM_STACKS];
  logic [sps_pkg::LINK_W-1:0]     free_head;
  logic [sps_pkg::DATA_W-1:0]     data_mem  [sps_pkg::NUM_SLOTS];
  logic [sps_pkg::LINK_W-1:0]     link_mem  [sps_pkg::NUM_SLOTS];
  logic [sps_pkg::NUM_SLOTS-1:0]  link_vld;

  // captured beat and read data
  logic                           cmd_q;
  logic [sps_pkg::STK_W-1:0]      sid_q;
  logic [sps_pkg::DATA_W-1:0]     value_q;
  logic [sps_pkg::SLOT_W-1:0]     slot_q;
  logic                           ok_q;
  logic [sps_pkg::DATA_W-1:0]     data_rd;
  logic [sps_pkg::LINK_W-1:0]     link_rd;
  logic                           link_vld_rd;

  logic                           accept;
  logic                           sid_ok;
  logic [sps_pkg::STK_W-1:0]      sid_idx;
  logic [sps_pkg::LINK_W-1:0]     head_sel;
  logic                           ok_next;
  logic [sps_pkg::SLOT_W-1:0]     slot_next;
  logic                           out_free;
  logic                           commit;
  logic [sps_pkg::LINK_W-1:0]     link_eff;

  // handshake
  assign in_stall = (state != sps_pkg::ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign commit   = (state == sps_pkg::ST_EXEC) && out_free;

  // pick the slot this beat works on
  assign sid_idx   = sps_pkg::STK_W'(stack_id);
  assign sid_ok    = int'(stack_id) < sps_pkg::NUM_STACKS;
  assign head_sel  = (cmd == sps_pkg::CMD_PUSH) ? free_head : stack_top[sid_idx];
  assign ok_next   = sid_ok && (head_sel < sps_pkg::LINK_NULL);
  assign slot_next = head_sel[sps_pkg::SLOT_W-1:0];

  // unwritten links follow the reset chain
  always_comb begin
    if (link_vld_rd) begin
      link_eff = link_rd;
    end else if (slot_q == sps_pkg::SLOT_W'(sps_pkg::NUM_SLOTS - 1)) begin
      link_eff = sps_pkg::LINK_NULL;
    end else begin
      link_eff = sps_pkg::LINK_W'(slot_q) + sps_pkg::LINK_W'(1);
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sps_pkg::ST_IDLE;
    end else begin
      unique case (state)
        sps_pkg::ST_IDLE: if (accept) state <= sps_pkg::ST_EXEC;
        sps_pkg::ST_EXEC: if (commit) state <= sps_pkg::ST_IDLE;
        default:          state <= sps_pkg::ST_IDLE;
      endcase
    end
  end

  // beat capture
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q   <= cmd;
      sid_q   <= sid_idx;
      value_q <= value;
      slot_q  <= slot_next;
      ok_q    <= ok_next;
    end
  end

  // data memory
  always_ff @(posedge clk) begin
    if (commit && ok_q && (cmd_q == sps_pkg::CMD_PUSH)) begin
      data_mem[slot_q] <= value_q;
    end
    if (accept) begin
      data_rd <= data_mem[slot_next];
    end
  end

  // link memory
  always_ff @(posedge clk) begin
    if (commit && ok_q) begin
      link_mem[slot_q] <= (cmd_q == sps_pkg::CMD_PUSH) ? stack_top[sid_q] : free_head;
    end
    if (accept) begin
      link_rd <= link_mem[slot_next];
    end
  end

  // link valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      link_vld    <= '0;
      link_vld_rd <= 1'b0;
    end else begin
      if (commit && ok_q) link_vld[slot_q] <= 1'b1;
      if (accept) link_vld_rd <= link_vld[slot_next];
    end
  end

  // stack tops and free head
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < sps_pkg::NUM_STACKS; i++) begin
        stack_top[i] <= sps_pkg::LINK_NULL;
      end
      free_head <= '0;
    end else if (commit && ok_q) begin
      if (cmd_q == sps_pkg::CMD_PUSH) begin
        stack_top[sid_q] <= sps_pkg::LINK_W'(slot_q);
        free_head        <= link_eff;
      end else begin
        stack_top[sid_q] <= link_eff;
        free_head        <= sps_pkg::LINK_W'(slot_q);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      if (ok_q) begin
        status <= sps_pkg::STAT_DONE;
      end else if (cmd_q == sps_pkg::CMD_PUSH) begin
        status <= sps_pkg::STAT_FULL;
      end else begin
        status <= sps_pkg::STAT_EMPTY;
      end
      popped_value <= (ok_q && (cmd_q == sps_pkg::CMD_POP)) ? data_rd : '0;
    end
  end

  // checks
  `include "shared_pool_multi_stack_assert.svh"

  `SPS_ASSERT_NEXT(a_accept_to_exec, clk, rst, accept, state == sps_pkg::ST_EXEC)
  `SPS_ASSERT_NEXT(a_commit_loads_out, clk, rst, commit, out_valid && state == sps_pkg::ST_IDLE)
  `SPS_ASSERT_NOW(a_fail_zero, clk, rst, out_valid && status != sps_pkg::STAT_DONE, popped_value == '0)
  `SPS_ASSERT_NOW(a_rise_after_exec, clk, rst, $rose(out_valid), $past(state) == sps_pkg::ST_EXEC)

endmodule
